/* hw/rtl/scd_pkg.sv */
// ============================================================================
// Serial command deframer package
// Shared types, codes and defaults for the deframer top level and its core.
// ============================================================================
package scd_pkg;

    // Frame buffer length; the byte counter saturates at one below it.
    localparam int unsigned BufLenDefault = 32;

    // Configuration port.
    localparam int unsigned AddrWidth     = 2;
    localparam int unsigned DataWidth     = 32;
    localparam logic [AddrWidth-1:0] ADDR_HEADER_BYTE = 2'd0;
    localparam logic [7:0]           HEADER_BYTE_RESET = 8'hAA;

    // Item kinds on the input channel.
    localparam logic KIND_RX_BYTE = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    // Frame status as reported on the result channel.
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_COLLECT = 2'd1,
        ST_READY   = 2'd2
    } status_t;

    // One result beat as produced by the core.
    typedef struct packed {
        status_t    frame_status;
        logic       byte_stored;
        logic [4:0] byte_position;
        logic       frame_good;
        logic       frame_bad;
        logic [4:0] frame_total;
    } result_t;

endpackage

/* hw/rtl/scd_core.sv */
// ============================================================================
// Deframer core
// Frame state (status, byte count, length, running XOR) and the per-beat
// parsing logic. State advances only when the top level strobes proc_en.
// ============================================================================
module scd_core #(
    parameter int unsigned BUF_LEN = scd_pkg::BufLenDefault
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            proc_en,
    input  logic            kind,
    input  logic [7:0]      rx_byte,
    input  logic [7:0]      header_byte,
    output scd_pkg::result_t res
);
    import scd_pkg::*;

    localparam int unsigned CW = $clog2(BUF_LEN);
    localparam logic [CW-1:0] CNT_MAX = CW'(BUF_LEN - 1);
    localparam logic [CW-1:0] CNT_LEN = CW'(2);

    status_t       status_reg, status_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    xor_reg, xor_next;

    // Header restart view of the state.
    logic          is_header;
    status_t       status0;
    logic [CW-1:0] cnt0;
    logic [CW-1:0] cnt1;
    logic [7:0]    len0;
    logic [7:0]    len1;
    logic [7:0]    xor0;
    logic          done;
    logic [CW+4:0] cnt0_ext;
    logic [CW+4:0] cnt1_ext;

    assign is_header = (rx_byte == header_byte);
    assign status0   = is_header ? ST_COLLECT : status_reg;
    assign cnt0      = is_header ? '0 : count_reg;
    assign len0      = is_header ? 8'd0 : len_reg;
    assign xor0      = is_header ? 8'd0 : xor_reg;

    // Next position, saturating at the last buffer slot.
    assign cnt1 = (cnt0 == CNT_MAX) ? CNT_MAX : cnt0 + 1'b1;
    // The second stored byte carries the length.
    assign len1 = (cnt1 == CNT_LEN) ? rx_byte : len0;
    // Frame completes when count equals length plus header and length bytes.
    assign done = (len1 != 8'd0) && (({1'b0, len1} + 9'd2) == 9'(cnt1));

    assign cnt0_ext = {5'd0, cnt0};
    assign cnt1_ext = {5'd0, cnt1};

    // Parse one beat.
    always_comb begin
        status_next = status_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        xor_next    = xor_reg;
        res         = '0;
        res.frame_status = status_reg;
        if (kind == KIND_ACK) begin
            if (status_reg == ST_READY) begin
                status_next = ST_IDLE;
            end
        end else begin
            status_next = status0;
            count_next  = cnt0;
            len_next    = len0;
            xor_next    = xor0;
            if (status0 == ST_COLLECT) begin
                res.byte_stored   = 1'b1;
                res.byte_position = cnt0_ext[4:0];
                count_next        = cnt1;
                len_next          = len1;
                if (done) begin
                    len_next        = 8'd0;
                    res.frame_total = cnt1_ext[4:0];
                    if (xor0 == rx_byte) begin
                        res.frame_good = 1'b1;
                        status_next    = ST_READY;
                    end else begin
                        res.frame_bad = 1'b1;
                    end
                end else if (cnt0 != '0) begin
                    xor_next = xor0 ^ rx_byte;
                end
            end
        end
        res.frame_status = status_next;
    end

    // Frame state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= ST_IDLE;
            count_reg  <= '0;
            len_reg    <= 8'd0;
            xor_reg    <= 8'd0;
        end else if (proc_en) begin
            status_reg <= status_next;
            count_reg  <= count_next;
            len_reg    <= len_next;
            xor_reg    <= xor_next;
        end
    end

endmodule

/* hw/rtl/serial_command_deframer.sv */
// ============================================================================
// Serial command deframer
// Parses header / length / payload / XOR-checksum frames from a byte stream.
// ============================================================================
// Usage: each input beat carries either a received byte (s_kind = 0) or an
// acknowledge of a ready frame (s_kind = 1). Every input beat produces exactly
// one result beat with the frame status after that beat, where the byte was
// stored, and whether it completed a frame with a good or bad checksum.
// A byte equal to the header register always restarts a frame.
// The header byte is set through the APB port at address 0 (reset 0xAA).
// Each beat passes through the input register, then through the parse logic
// into the result register. Throughput is one beat per cycle while the
// receiver does not stall, set by the per-beat frame state update in the core.
// When the receiver stalls, the result register holds its beat and the input
// register fills; s_ready drops only when both are occupied.
// Reset (aresetn low, synchronous) empties both registers, returns the frame
// state to idle and restores the header byte to 0xAA.
// ============================================================================
module serial_command_deframer #(
    parameter int unsigned BUF_LEN = scd_pkg::BufLenDefault
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [7:0]                      s_rx_byte,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_frame_status,
    output logic                            m_byte_stored,
    output logic [4:0]                      m_byte_position,
    output logic                            m_frame_good,
    output logic                            m_frame_bad,
    output logic [4:0]                      m_frame_total,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [scd_pkg::AddrWidth-1:0]   paddr,
    input  logic [scd_pkg::DataWidth-1:0]   pwdata,
    output logic [scd_pkg::DataWidth-1:0]   prdata,
    output logic                            pready
);
    import scd_pkg::*;

    logic       header_reg;
    logic [7:0] header_byte_reg;
    logic       in_valid_reg;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    core_res;
    logic       advance;

    // Configuration register.
    assign pready = 1'b1;
    assign header_reg = psel && penable && pwrite && (paddr == ADDR_HEADER_BYTE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_byte_reg <= HEADER_BYTE_RESET;
        end else if (header_reg) begin
            header_byte_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_HEADER_BYTE) begin
            prdata = {{(DataWidth-8){1'b0}}, header_byte_reg};
        end
    end

    // Pipeline control: the parse stage moves when the result slot is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_byte_reg <= s_rx_byte;
        end
    end

    // Parsing core with the frame state.
    scd_core #(
        .BUF_LEN (BUF_LEN)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .proc_en     (advance),
        .kind        (in_kind_reg),
        .rx_byte     (in_byte_reg),
        .header_byte (header_byte_reg),
        .res         (core_res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_frame_status  = out_reg.frame_status;
    assign m_byte_stored   = out_reg.byte_stored;
    assign m_byte_position = out_reg.byte_position;
    assign m_frame_good    = out_reg.frame_good;
    assign m_frame_bad     = out_reg.frame_bad;
    assign m_frame_total   = out_reg.frame_total;

endmodule

/* dv/tb_serial_command_deframer.sv */
// ============================================================================
// Serial command deframer testbench
// Sends received bytes and acknowledges through the valid/ready input channel
// and predicts every result beat with a behavioral copy of the frame parser:
// header restart, length byte, running XOR checksum, count saturation and the
// ready/acknowledge handshake. Each result beat is compared field by field.
// The header register is reprogrammed over the APB port between traffic
// phases, including the extreme values, and read back after each write.
// ============================================================================
module tb_serial_command_deframer;
    import scd_pkg::*;

    localparam int unsigned BUF_LEN      = BufLenDefault;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned PHASE_BEATS  = 340;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_RANDOM,
        RX_PERIODIC
    } rx_pace_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic                 s_kind    = KIND_RX_BYTE;
    logic [7:0]           s_rx_byte = 8'h00;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [1:0]           m_frame_status;
    logic                 m_byte_stored;
    logic [4:0]           m_byte_position;
    logic                 m_frame_good;
    logic                 m_frame_bad;
    logic [4:0]           m_frame_total;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [AddrWidth-1:0] paddr     = '0;
    logic [DataWidth-1:0] pwdata    = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    // Parser state as predicted by the testbench.
    logic [7:0]  hdr_value = HEADER_BYTE_RESET;
    status_t     fr_status = ST_IDLE;
    int unsigned fr_count  = 0;
    logic [7:0]  fr_len    = 8'h00;
    logic [7:0]  fr_xor    = 8'h00;

    // Results still owed by the block, oldest first.
    result_t     pending_results[$];

    int unsigned errors       = 0;
    int unsigned cycle_count  = 0;
    int unsigned live_beats   = 0;
    int unsigned beats_seen   = 0;
    int unsigned good_frames  = 0;
    int unsigned bad_frames   = 0;
    int unsigned acks_cleared = 0;
    int unsigned burst_left   = 0;
    bit          sender_gaps  = 1'b1;
    rx_pace_t    rx_pace      = RX_RANDOM;

    serial_command_deframer DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_status  (m_frame_status),
        .m_byte_stored   (m_byte_stored),
        .m_byte_position (m_byte_position),
        .m_frame_good    (m_frame_good),
        .m_frame_bad     (m_frame_bad),
        .m_frame_total   (m_frame_total),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Clock with a period of two time units.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver backpressure follows the pattern chosen for the phase.
    always @(posedge aclk) begin
        case (rx_pace)
            RX_STEADY: begin
                m_ready <= 1'b1;
            end
            RX_RANDOM: begin
                m_ready <= ($urandom_range(99) >= 40);
            end
            default: begin
                m_ready <= ((cycle_count % 11) < 6);
            end
        endcase
    end

    // Advance the predicted parser by one input beat and return its result.
    function automatic result_t predict_beat(input logic kind, input logic [7:0] rx);
        result_t     res;
        bit          done;
        int unsigned pos;
        res  = '0;
        done = 1'b0;
        if (kind == KIND_ACK) begin
            if (fr_status == ST_READY) begin
                fr_status = ST_IDLE;
                acks_cleared++;
                live_beats++;
            end
        end else begin
            // The header byte restarts a frame from any state.
            if (rx == hdr_value) begin
                fr_status = ST_COLLECT;
                fr_count  = 0;
                fr_len    = 8'h00;
                fr_xor    = 8'h00;
            end
            if (fr_status == ST_COLLECT) begin
                live_beats++;
                pos               = fr_count;
                res.byte_stored   = 1'b1;
                res.byte_position = pos[4:0];
                fr_count          = fr_count + 1;
                if (fr_count >= BUF_LEN) begin
                    fr_count = BUF_LEN - 1;
                end
                if (fr_count == 2) begin
                    fr_len = rx;
                end
                // Completion: the count has covered the length plus header and length.
                if (fr_len != 0 && fr_count >= 2 && fr_count - 2 == fr_len) begin
                    done            = 1'b1;
                    fr_len          = 8'h00;
                    res.frame_total = fr_count[4:0];
                    if (fr_xor == rx) begin
                        res.frame_good = 1'b1;
                        fr_status      = ST_READY;
                        good_frames++;
                    end else begin
                        res.frame_bad = 1'b1;
                        bad_frames++;
                    end
                end
                if (!done && pos >= 1) begin
                    fr_xor = fr_xor ^ rx;
                end
            end
        end
        res.frame_status = fr_status;
        return res;
    endfunction

    task automatic compare_field(input string fname, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    // Predict on every accepted input beat, check every accepted result beat.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_results.push_back(predict_beat(s_kind, s_rx_byte));
            end
            if (m_valid && m_ready) begin
                beats_seen++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, actual status %0d",
                             $time, m_frame_status);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("frame_status", want.frame_status, m_frame_status);
                    compare_field("byte_stored", want.byte_stored, m_byte_stored);
                    compare_field("byte_position", want.byte_position, m_byte_position);
                    compare_field("frame_good", want.frame_good, m_frame_good);
                    compare_field("frame_bad", want.frame_bad, m_frame_bad);
                    compare_field("frame_total", want.frame_total, m_frame_total);
                end
            end
        end
    end

    // Send one beat; with sender_gaps set, the sender works in bursts separated by random gaps.
    task automatic send_beat(input logic kind, input logic [7:0] rx);
        if (sender_gaps) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge aclk);
                burst_left = $urandom_range(12, 1);
            end
            burst_left--;
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait until every owed result beat has been checked.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Program the header register over APB and read it back.
    task automatic write_header(input logic [7:0] value);
        logic [DataWidth-1:0] word;
        word       = $urandom;
        word[7:0]  = value;
        psel      <= 1'b1;
        penable   <= 1'b0;
        pwrite    <= 1'b1;
        paddr     <= ADDR_HEADER_BYTE;
        pwdata    <= word;
        @(posedge aclk);
        penable   <= 1'b1;
        @(posedge aclk);
        hdr_value  = value;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        @(posedge aclk);
        penable   <= 1'b1;
        @(posedge aclk);
        if (prdata[7:0] !== value) begin
            errors++;
            $display("%0t: header readback mismatch, expected %0d, actual %0d",
                     $time, value, prdata[7:0]);
        end
        psel      <= 1'b0;
        penable   <= 1'b0;
    endtask

    // Payload byte that mostly avoids restarting the frame.
    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == hdr_value && $urandom_range(19) != 0);
        return b;
    endfunction

    // Length byte, mostly short, with zero, the longest that fits and too long.
    function automatic logic [7:0] frame_length();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 3) return 8'd0;
        if (p < 8) return 8'(BUF_LEN - 3);
        if (p < 13) return 8'($urandom_range(255, BUF_LEN - 2));
        if (p < 25) return 8'($urandom_range(BUF_LEN - 4, 9));
        return 8'($urandom_range(8, 1));
    endfunction

    // Header, length, payload and checksum; lengths that never complete get
    // a run of payload long enough to reach count saturation at times.
    task automatic send_frame(input logic [7:0] len, input bit corrupt);
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned n;
        bit          fits;
        fits = (len != 0 && len <= BUF_LEN - 3);
        n    = fits ? len - 1 : $urandom_range(36, 1);
        sum  = len;
        send_beat(KIND_RX_BYTE, hdr_value);
        send_beat(KIND_RX_BYTE, len);
        repeat (n) begin
            b   = payload_byte();
            sum = sum ^ b;
            send_beat(KIND_RX_BYTE, b);
        end
        if (fits) begin
            if (corrupt) begin
                sum = sum ^ (8'h01 << $urandom_range(7));
            end
            send_beat(KIND_RX_BYTE, sum);
        end
    endtask

    // Bytes and acknowledges while no frame is open are ignored.
    task automatic test_idle_beats();
        send_beat(KIND_ACK, 8'h00);
        send_beat(KIND_RX_BYTE, 8'h00);
        send_beat(KIND_RX_BYTE, 8'hFF);
        send_beat(KIND_RX_BYTE, 8'h55);
    endtask

    // Good frames, a byte while ready, and acknowledges in and out of ready.
    task automatic test_complete_frames();
        send_frame(8'd1, 1'b0);
        send_frame(8'd3, 1'b0);
        send_beat(KIND_RX_BYTE, 8'h5A);
        send_beat(KIND_ACK, 8'hFF);
        send_beat(KIND_ACK, 8'h00);
    endtask

    // A bad checksum keeps collecting without a second completion.
    task automatic test_checksum_errors();
        send_frame(8'd2, 1'b1);
        send_beat(KIND_RX_BYTE, 8'h00);
        send_beat(KIND_RX_BYTE, 8'hFF);
    endtask

    // A header mid-frame restarts, and a zero length never completes.
    task automatic test_frame_restart();
        send_beat(KIND_RX_BYTE, hdr_value);
        send_beat(KIND_RX_BYTE, 8'd4);
        send_beat(KIND_RX_BYTE, 8'h01);
        send_frame(8'd0, 1'b0);
        wait_drained();
    endtask

    // Mostly well-formed frames with random content, plus broken frames,
    // noise and occasional full drains of the pipeline.
    task automatic test_random_traffic(input logic [7:0] header, input rx_pace_t pace,
                                       input bit gaps);
        int unsigned target;
        int unsigned pick;
        write_header(header);
        rx_pace     = pace;
        sender_gaps = gaps;
        target      = live_beats + PHASE_BEATS;
        while (live_beats < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_frame(frame_length(), $urandom_range(7) == 0);
                if ($urandom_range(3) != 0) begin
                    send_beat(KIND_ACK, 8'($urandom));
                end
            end else if (pick < 84) begin
                // Truncated frame, cut short by whatever comes next.
                send_beat(KIND_RX_BYTE, hdr_value);
                repeat ($urandom_range(6)) send_beat(KIND_RX_BYTE, 8'($urandom));
            end else if (pick < 98) begin
                repeat ($urandom_range(4, 1)) begin
                    send_beat(1'($urandom_range(1)), 8'($urandom));
                end
            end else begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_beats();
        test_complete_frames();
        test_checksum_errors();
        test_frame_restart();

        test_random_traffic(8'h00, RX_RANDOM, 1'b1);
        test_random_traffic(8'hFF, RX_PERIODIC, 1'b1);
        test_random_traffic(8'($urandom), RX_STEADY, 1'b0);
        test_random_traffic(HEADER_BYTE_RESET, RX_RANDOM, 1'b1);
        test_random_traffic(8'($urandom), RX_RANDOM, 1'b0);

        $display("Checked %0d result beats: %0d good frames, %0d bad, %0d acknowledged.",
                 beats_seen, good_frames, bad_frames, acks_cleared);
        $display("Headers 0x00, 0xFF, 0xAA and random; steady, random and periodic stalls.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* serial_command_deframer.f */
hw/rtl/scd_pkg.sv
hw/rtl/scd_core.sv
hw/rtl/serial_command_deframer.sv
dv/tb_serial_command_deframer.sv
